// File: hw/rtl/sdl_pkg.sv
// Shared types and constants for the sorted deque list.
package sdl_pkg;

  // Fixed field widths of the request and response beats
  localparam int unsigned OP_W   = 3;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned NUM_W  = 5;

  // Request operation codes
  typedef enum logic [OP_W-1:0] {
    OP_PUSH_HEAD = 3'd0,
    OP_PUSH_TAIL = 3'd1,
    OP_INSERT    = 3'd2,
    OP_POP_HEAD  = 3'd3,
    OP_POP_TAIL  = 3'd4,
    OP_REMOVE    = 3'd5,
    OP_CLEAR     = 3'd6
  } op_e;

  // Response status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_NOMATCH = 2'd3
  } status_e;

  // Command broadcast to every cell of the chain
  typedef enum logic [3:0] {
    CMD_HOLD      = 4'd0,
    CMD_PUSH_HEAD = 4'd1,
    CMD_PUSH_TAIL = 4'd2,
    CMD_POP_HEAD  = 4'd3,
    CMD_POP_TAIL  = 4'd4,
    CMD_CLEAR     = 4'd5,
    CMD_SCAN_INS  = 4'd6,
    CMD_SCAN_REM  = 4'd7,
    CMD_INS_MARK  = 4'd8,
    CMD_SWAP      = 4'd9
  } cell_cmd_e;

  typedef struct packed {
    cell_cmd_e               cmd;
    logic                    phase;  // odd-even pairing for compaction
    logic signed [VAL_W-1:0] value;
  } cell_ctl_t;

  // Scan token walking down the chain, one cell per cycle
  typedef struct packed {
    logic tok;
    logic first;    // set only while entering the head cell
    logic found;    // a larger-or-equal entry was seen
    logic head_ge;  // head entry is >= value
    logic tail_le;  // tail entry is <= value
  } scan_t;

  // What a cell shows its neighbors
  typedef struct packed {
    logic                    valid;
    logic                    shift;
    logic signed [VAL_W-1:0] data;
  } nbr_t;

endpackage

// File: hw/rtl/sdl_if.sv
// Request and response channel interfaces of the sorted deque list.
interface sdl_req_if import sdl_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         op;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, op, value, input ready);
  modport sink   (input valid, op, value, output ready);
endinterface

interface sdl_rsp_if import sdl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [NUM_W-1:0]  removed_count;
  logic [NUM_W-1:0]  length;

  modport source (output valid, status, removed_count, length, input ready);
  modport sink   (input valid, status, removed_count, length, output ready);
endinterface

// File: hw/rtl/sdl_cell.sv
// One list cell: an entry, its valid bit, an insert mark and a scan stage.
module sdl_cell import sdl_pkg::*; #(
  parameter int unsigned CNT_W = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_ctl_t        ctl_i,
  input  logic             odd_i,
  input  nbr_t             left_i,
  input  nbr_t             right_i,
  output nbr_t             view_o,
  input  scan_t            scan_i,
  output scan_t            scan_o,
  input  logic [CNT_W-1:0] cnt_i,
  output logic [CNT_W-1:0] cnt_o
);

  logic                    valid_q, valid_d;
  logic                    shift_q, shift_d;
  logic signed [VAL_W-1:0] data_q, data_d;
  scan_t                   scan_q;
  logic [CNT_W-1:0]        cnt_q;
  logic                    ge, le, eq, lower;

  assign ge    = $signed(data_q) >= $signed(ctl_i.value);
  assign le    = $signed(data_q) <= $signed(ctl_i.value);
  assign eq    = data_q == ctl_i.value;
  assign lower = odd_i == ctl_i.phase;

  assign view_o = '{valid: valid_q, shift: shift_q, data: data_q};

  // Token leaving this cell, with this cell's contribution folded in
  always_comb begin
    scan_o.tok     = scan_q.tok;
    scan_o.first   = 1'b0;
    scan_o.found   = scan_q.tok & (scan_q.found | (valid_q & ge));
    scan_o.head_ge = scan_q.tok & (scan_q.head_ge | (scan_q.first & valid_q & ge));
    scan_o.tail_le = scan_q.tok & (scan_q.tail_le | (valid_q & ~right_i.valid & le));
    cnt_o          = cnt_q + CNT_W'(scan_q.tok & valid_q & eq);
  end

  // Next entry state per broadcast command
  always_comb begin
    valid_d = valid_q;
    shift_d = shift_q;
    data_d  = data_q;
    unique case (ctl_i.cmd)
      CMD_PUSH_HEAD: begin
        data_d  = left_i.data;
        valid_d = left_i.valid;
      end
      CMD_PUSH_TAIL: begin
        shift_d = 1'b0;
        if (!valid_q && left_i.valid) begin
          data_d  = ctl_i.value;
          valid_d = 1'b1;
        end
      end
      CMD_POP_HEAD: begin
        data_d  = right_i.data;
        valid_d = right_i.valid;
      end
      CMD_POP_TAIL: begin
        if (valid_q && !right_i.valid) valid_d = 1'b0;
      end
      CMD_CLEAR: begin
        valid_d = 1'b0;
        shift_d = 1'b0;
      end
      CMD_SCAN_INS: begin
        if (scan_q.tok && valid_q && (scan_q.found || ge)) shift_d = 1'b1;
      end
      CMD_SCAN_REM: begin
        if (scan_q.tok && valid_q && eq) valid_d = 1'b0;
      end
      CMD_INS_MARK: begin
        shift_d = 1'b0;
        if (shift_q) begin
          data_d = left_i.shift ? left_i.data : ctl_i.value;
        end else if (!valid_q && left_i.shift) begin
          data_d  = left_i.data;
          valid_d = 1'b1;
        end
      end
      CMD_SWAP: begin
        // odd-even pass: holes move toward the tail, survivors keep order
        if (lower) begin
          if (!valid_q && right_i.valid) begin
            data_d  = right_i.data;
            valid_d = 1'b1;
          end
        end else if (valid_q && !left_i.valid) begin
          valid_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      shift_q <= 1'b0;
      scan_q  <= '0;
      cnt_q   <= '0;
    end else begin
      valid_q <= valid_d;
      shift_q <= shift_d;
      scan_q  <= scan_i;
      cnt_q   <= cnt_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

// File: hw/rtl/sdl_ctrl.sv
// Sequencer: handshakes, occupancy, scan and compaction control, response register.
module sdl_ctrl import sdl_pkg::*; #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  sdl_req_if.sink          req_i,
  sdl_rsp_if.source        rsp_o,
  output cell_ctl_t        ctl_o,
  output scan_t            inject_o,
  input  scan_t            tail_i,
  input  logic [CNT_W-1:0] tail_cnt_i
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;
  localparam logic [2:0] S_MARK    = 3'd2;
  localparam logic [2:0] S_COMPACT = 3'd3;
  localparam logic [2:0] S_DONE    = 3'd4;

  logic [2:0]              state_q, state_d;
  logic [CNT_W-1:0]        occ_q, occ_d;
  logic [CNT_W-1:0]        round_q, round_d;
  logic                    ins_q, ins_d;
  logic                    use_mark_q, use_mark_d;
  logic signed [VAL_W-1:0] value_q, value_d;
  logic [STAT_W-1:0]       pend_status_q, pend_status_d;
  logic [NUM_W-1:0]        pend_removed_q, pend_removed_d;
  logic                    ov_q, ov_d;
  logic [STAT_W-1:0]       out_status_q, out_status_d;
  logic [NUM_W-1:0]        out_removed_q, out_removed_d;
  logic [NUM_W-1:0]        out_length_q, out_length_d;
  logic                    slot_free, full, empty, finish;
  logic [STAT_W-1:0]       res_status;
  logic [NUM_W-1:0]        res_removed;

  assign full      = occ_q == CNT_W'(DEPTH);
  assign empty     = occ_q == '0;
  assign slot_free = ~ov_q | rsp_o.ready;

  assign req_i.ready         = state_q == S_IDLE;
  assign rsp_o.valid         = ov_q;
  assign rsp_o.status        = out_status_q;
  assign rsp_o.removed_count = out_removed_q;
  assign rsp_o.length        = out_length_q;

  always_comb begin
    state_d        = state_q;
    occ_d          = occ_q;
    round_d        = round_q;
    ins_d          = ins_q;
    use_mark_d     = use_mark_q;
    value_d        = value_q;
    pend_status_d  = pend_status_q;
    pend_removed_d = pend_removed_q;
    ov_d           = ov_q & ~rsp_o.ready;
    out_status_d   = out_status_q;
    out_removed_d  = out_removed_q;
    out_length_d   = out_length_q;
    ctl_o.cmd      = CMD_HOLD;
    ctl_o.phase    = round_q[0];
    ctl_o.value    = value_q;
    inject_o       = '0;
    inject_o.first = 1'b1;
    finish         = 1'b0;
    res_status     = ST_OK;
    res_removed    = '0;

    unique case (state_q)
      S_IDLE: begin
        ctl_o.value = req_i.value;
        if (req_i.valid) begin
          value_d = req_i.value;
          ins_d   = req_i.op == OP_INSERT;
          finish  = 1'b1;
          case (req_i.op)
            OP_PUSH_HEAD, OP_PUSH_TAIL: begin
              if (full) begin
                res_status = ST_FULL;
              end else begin
                ctl_o.cmd = (req_i.op == OP_PUSH_HEAD) ? CMD_PUSH_HEAD : CMD_PUSH_TAIL;
                occ_d     = occ_q + CNT_W'(1);
              end
            end
            OP_INSERT: begin
              if (full) begin
                res_status = ST_FULL;
              end else if (empty) begin
                ctl_o.cmd = CMD_PUSH_TAIL;
                occ_d     = occ_q + CNT_W'(1);
              end else begin
                finish       = 1'b0;
                inject_o.tok = 1'b1;
                state_d      = S_SCAN;
              end
            end
            OP_POP_HEAD, OP_POP_TAIL: begin
              if (empty) begin
                res_status = ST_EMPTY;
              end else begin
                ctl_o.cmd   = (req_i.op == OP_POP_HEAD) ? CMD_POP_HEAD : CMD_POP_TAIL;
                occ_d       = occ_q - CNT_W'(1);
                res_removed = NUM_W'(1);
              end
            end
            OP_REMOVE: begin
              finish       = 1'b0;
              inject_o.tok = 1'b1;
              state_d      = S_SCAN;
            end
            OP_CLEAR: begin
              ctl_o.cmd   = CMD_CLEAR;
              res_removed = NUM_W'(occ_q);
              occ_d       = '0;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        ctl_o.cmd = ins_q ? CMD_SCAN_INS : CMD_SCAN_REM;
        // token leaves the last cell: the whole list has been looked at
        if (tail_i.tok) begin
          if (ins_q) begin
            use_mark_d = tail_i.head_ge | ~tail_i.tail_le;
            state_d    = S_MARK;
          end else begin
            occ_d          = occ_q - tail_cnt_i;
            pend_status_d  = (tail_cnt_i == '0) ? ST_NOMATCH : ST_OK;
            pend_removed_d = NUM_W'(tail_cnt_i);
            round_d        = '0;
            state_d        = S_COMPACT;
          end
        end
      end
      S_MARK: begin
        ctl_o.cmd      = use_mark_q ? CMD_INS_MARK : CMD_PUSH_TAIL;
        occ_d          = occ_q + CNT_W'(1);
        pend_status_d  = ST_OK;
        pend_removed_d = '0;
        state_d        = S_DONE;
      end
      S_COMPACT: begin
        ctl_o.cmd = CMD_SWAP;
        round_d   = round_q + CNT_W'(1);
        if (round_q == CNT_W'(DEPTH - 1)) state_d = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          ov_d          = 1'b1;
          out_status_d  = pend_status_q;
          out_removed_d = pend_removed_q;
          out_length_d  = NUM_W'(occ_q);
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // ops done at acceptance: straight to the response register, or park the result
    if (finish) begin
      if (slot_free) begin
        ov_d          = 1'b1;
        out_status_d  = res_status;
        out_removed_d = res_removed;
        out_length_d  = NUM_W'(occ_d);
      end else begin
        pend_status_d  = res_status;
        pend_removed_d = res_removed;
        state_d        = S_DONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      occ_q      <= '0;
      round_q    <= '0;
      ins_q      <= 1'b0;
      use_mark_q <= 1'b0;
      ov_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      occ_q      <= occ_d;
      round_q    <= round_d;
      ins_q      <= ins_d;
      use_mark_q <= use_mark_d;
      ov_q       <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q        <= value_d;
    pend_status_q  <= pend_status_d;
    pend_removed_q <= pend_removed_d;
    out_status_q   <= out_status_d;
    out_removed_q  <= out_removed_d;
    out_length_q   <= out_length_d;
  end

  // occupancy stays within the cell count
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CNT_W'(DEPTH))
    else $error("occupancy above depth");

  // a token only reaches the chain end during a scan
  a_tok_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_i.tok |-> state_q == S_SCAN)
    else $error("scan token outside scan");

  // clear empties the list at once
  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready && req_i.op == OP_CLEAR) |=> occ_q == '0)
    else $error("clear left entries");

endmodule

// File: hw/rtl/sorted_deque_list.sv
// Top level of the sorted deque list: a chain of cells driven by one sequencer.
//
//  channel  | dir | payload                          | accepted when
//  ---------+-----+----------------------------------+---------------------
//  req_i    | in  | op[2:0], value[31:0] signed      | valid && ready
//  rsp_o    | out | status[1:0], removed_count[4:0], | valid && ready
//           |     | length[4:0]                      |
//
// Push, pop, clear, the unused code, dropped pushes and a sorted insert into an
// empty list finish on acceptance, the response registered on the accepting edge
// if the output is free. Other sorted inserts scan, then mark, and remove-value
// always scans, then compacts: a scan token walks one cell per cycle, and
// compaction is DEPTH odd-even passes. Reset clears valid bits and counters; entry
// data are not reset. A stalled response waits in the output register; one more
// waits in the sequencer with req_i.ready low until the output register frees up.
module sorted_deque_list import sdl_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sdl_req_if.sink   req_i,
  sdl_rsp_if.source rsp_o
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cell_ctl_t        ctl;
  scan_t            scan_chain [DEPTH+1];
  logic [CNT_W-1:0] cnt_chain  [DEPTH+1];
  nbr_t             view       [DEPTH];
  nbr_t             left_pad, right_pad;
  logic [DEPTH-1:0] valid_vec, shift_vec, tok_vec;

  // Edge neighbors: the head sees the incoming value, the tail sees nothing
  assign left_pad  = '{valid: 1'b1, shift: 1'b0, data: ctl.value};
  assign right_pad = '{valid: 1'b0, shift: 1'b0, data: '0};
  assign cnt_chain[0] = '0;

  sdl_ctrl #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .rsp_o      (rsp_o),
    .ctl_o      (ctl),
    .inject_o   (scan_chain[0]),
    .tail_i     (scan_chain[DEPTH]),
    .tail_cnt_i (cnt_chain[DEPTH])
  );

  // Cell chain, head at index 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    nbr_t left_v, right_v;

    if (i == 0) begin : g_head
      assign left_v = left_pad;
    end else begin : g_mid_l
      assign left_v = view[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_v = right_pad;
    end else begin : g_mid_r
      assign right_v = view[i+1];
    end

    sdl_cell #(
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .odd_i   (1'(i % 2)),
      .left_i  (left_v),
      .right_i (right_v),
      .view_o  (view[i]),
      .scan_i  (scan_chain[i]),
      .scan_o  (scan_chain[i+1]),
      .cnt_i   (cnt_chain[i]),
      .cnt_o   (cnt_chain[i+1])
    );

    assign valid_vec[i] = view[i].valid;
    assign shift_vec[i] = view[i].shift;
    assign tok_vec[i]   = scan_chain[i+1].tok;
  end

  // at most one scan token in flight
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_vec))
    else $error("more than one scan token");

  // between operations the held entries are packed from the head
  a_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.ready |-> (valid_vec & (valid_vec + DEPTH'(1))) == '0)
    else $error("hole in the list");

  // insert marks never outlive an insert
  a_no_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.ready |-> shift_vec == '0)
    else $error("stale insert mark");

endmodule
